// ===== rtl/ax25p_pkg.sv =====
// ----------------------------------------------------------------------------
// AX.25 address field parser package
// Shared constants, codes and the result record passed between the parser
// core and its output register.
// ----------------------------------------------------------------------------
package ax25p_pkg;

    localparam int MAX_DIGIPEATERS_DFLT = 6;
    localparam int ADDR_LEN             = 7;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = ADDR_LEN * BYTE_W;
    localparam int BCNT_W   = 3;
    localparam int ANUM_W   = 4;
    localparam int HLEN_W   = 6;

    // Index of the SSID byte, the last one of an address.
    localparam logic [BCNT_W-1:0] LAST_BYTE = BCNT_W'(ADDR_LEN - 1);

    // SSID byte bit positions.
    localparam int EXT_BIT  = 0;
    localparam int DAMA_BIT = 5;
    localparam int CR_BIT   = 7;

    localparam logic signed [3:0] LAST_REP_NONE = -4'sd1;

    typedef enum logic {
        PH_PARSING = 1'b0,
        PH_SKIP    = 1'b1
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_DEST = 2'd0,
        ROLE_SRC  = 2'd1,
        ROLE_DIGI = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_TOO_MANY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CR_NONE = 2'd0,
        CR_CMD  = 2'd1,
        CR_RESP = 2'd2
    } cmd_resp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address_value;
        role_t             address_role;
        logic [2:0]        digi_index;
        logic              has_repeated;
        logic              field_done;
        status_t           status;
        cmd_resp_t         cmd_resp;
        logic              dama_seen;
        logic [2:0]        digi_total;
        logic signed [3:0] last_repeat;
        logic [HLEN_W-1:0] header_length;
    } result_t;

endpackage

// ===== rtl/ax25p_core.sv =====
// ----------------------------------------------------------------------------
// AX.25 address parser core
// Holds the per-frame parse state and works out, for each accepted byte,
// the next state and the result record (if the byte completes an address
// or ends parsing with an error).
// ----------------------------------------------------------------------------
module ax25p_core #(
    parameter int MAX_DIGIPEATERS = ax25p_pkg::MAX_DIGIPEATERS_DFLT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         beat,
    input  logic [ax25p_pkg::BYTE_W-1:0] frame_byte,
    input  logic                         frame_end,
    output logic                         res_valid,
    output ax25p_pkg::result_t           res
);
    import ax25p_pkg::*;

    phase_t                   phase_reg,   phase_next;
    logic [BCNT_W-1:0]        bcnt_reg,    bcnt_next;
    logic [ANUM_W-1:0]        anum_reg,    anum_next;
    logic [ADDR_W-1:0]        shift_reg,   shift_next;
    cmd_resp_t                cr_reg,      cr_next;
    logic                     dama_reg,    dama_next;
    logic signed [3:0]        lrep_reg,    lrep_next;

    logic                     parsing;
    logic                     addr_done;
    logic                     is_dest;
    logic                     is_src;
    logic                     is_digi;
    logic                     ext_end;
    logic                     too_many;
    logic                     short_err;
    logic [ADDR_W-1:0]        shifted;
    cmd_resp_t                cr_upd;
    logic                     dama_upd;
    logic signed [3:0]        lrep_upd;
    logic [ANUM_W:0]          digis_held;
    logic [ANUM_W-1:0]        digi_pos;
    logic [6:0]               hlen_full;

    assign parsing   = (phase_reg == PH_PARSING);
    assign addr_done = parsing && (bcnt_reg == LAST_BYTE);
    assign is_dest   = (anum_reg == '0);
    assign is_src    = (anum_reg == ANUM_W'(1));
    assign is_digi   = !is_dest && !is_src;
    assign shifted   = {shift_reg[ADDR_W-BYTE_W-1:0], frame_byte};
    assign digi_pos  = anum_reg - ANUM_W'(2);

    // Digipeaters held up to and including this address: address number minus one.
    assign digis_held = {1'b0, anum_reg} - (ANUM_W+1)'(1);

    // The destination never ends the field; its extension bit is ignored.
    assign ext_end   = addr_done && !is_dest && frame_byte[EXT_BIT];
    assign too_many  = addr_done && !is_dest && !frame_byte[EXT_BIT]
                       && (digis_held >= (ANUM_W+1)'(MAX_DIGIPEATERS));
    assign short_err = parsing && frame_end && !ext_end && !too_many;

    assign cr_upd   = (addr_done && is_dest) ?
                          (frame_byte[CR_BIT] ? CR_CMD : CR_NONE) :
                      (addr_done && is_src && frame_byte[CR_BIT]) ? CR_RESP : cr_reg;
    assign dama_upd = (addr_done && is_src) ? !frame_byte[DAMA_BIT] : dama_reg;
    assign lrep_upd = (addr_done && is_digi && frame_byte[CR_BIT]) ?
                          4'(digi_pos) : lrep_reg;

    assign hlen_full = 7'(ADDR_LEN) * (7'(anum_reg) + 7'd1);

    // Next state. Every byte marked as frame end returns to a clean start.
    always_comb begin
        phase_next = phase_reg;
        bcnt_next  = bcnt_reg;
        anum_next  = anum_reg;
        shift_next = shift_reg;
        cr_next    = cr_reg;
        dama_next  = dama_reg;
        lrep_next  = lrep_reg;
        if (frame_end) begin
            phase_next = PH_PARSING;
            bcnt_next  = '0;
            anum_next  = '0;
            shift_next = '0;
            cr_next    = CR_NONE;
            dama_next  = 1'b0;
            lrep_next  = LAST_REP_NONE;
        end else if (parsing) begin
            shift_next = shifted;
            cr_next    = cr_upd;
            dama_next  = dama_upd;
            lrep_next  = lrep_upd;
            if (!addr_done) begin
                bcnt_next = bcnt_reg + BCNT_W'(1);
            end else begin
                bcnt_next = '0;
                if (ext_end || too_many) begin
                    phase_next = PH_SKIP;
                end else begin
                    anum_next = anum_reg + ANUM_W'(1);
                end
            end
        end
    end

    // Result record for this byte.
    always_comb begin
        res_valid = parsing && (addr_done || frame_end);
        res       = '0;
        if (too_many) begin
            res.field_done = 1'b1;
            res.status     = ST_TOO_MANY;
        end else if (short_err) begin
            res.field_done = 1'b1;
            res.status     = ST_SHORT;
        end else begin
            res.address_value = shifted;
            res.address_role  = is_dest ? ROLE_DEST : (is_src ? ROLE_SRC : ROLE_DIGI);
            res.digi_index    = is_digi ? digi_pos[2:0] : 3'd0;
            res.has_repeated  = is_digi && frame_byte[CR_BIT];
            if (ext_end) begin
                res.field_done    = 1'b1;
                res.status        = ST_OK;
                res.cmd_resp      = cr_upd;
                res.dama_seen     = dama_upd;
                res.digi_total    = digis_held[2:0];
                res.last_repeat   = lrep_upd;
                res.header_length = hlen_full[HLEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PARSING;
            bcnt_reg  <= '0;
            anum_reg  <= '0;
            cr_reg    <= CR_NONE;
            dama_reg  <= 1'b0;
            lrep_reg  <= LAST_REP_NONE;
        end else if (beat) begin
            phase_reg <= phase_next;
            bcnt_reg  <= bcnt_next;
            anum_reg  <= anum_next;
            cr_reg    <= cr_next;
            dama_reg  <= dama_next;
            lrep_reg  <= lrep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== rtl/ax25p_out_reg.sv =====
// ----------------------------------------------------------------------------
// AX.25 address parser output register
// Holds one result record for the output channel and lets a new byte in
// whenever the register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module ax25p_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  ax25p_pkg::result_t load_data,
    output logic               accept_ok,
    output logic               m_valid,
    input  logic               m_ready,
    output ax25p_pkg::result_t m_data
);
    import ax25p_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign accept_ok = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/ax25_address_field_parser.sv =====
// ----------------------------------------------------------------------------
// AX.25 address field parser
// Takes frame bytes one beat at a time on the s_ channel and returns one
// beat on the m_ channel for each completed 7-byte address (destination,
// source, digipeaters) or for a parse error. The beat that ends the address
// field (extension bit set) carries the field summary; it and every error
// beat have m_field_done high. Bytes after the field are dropped until the
// byte marked with s_frame_end, which always restarts parsing.
// Throughput is one byte per cycle while s_ready is high. A result is
// presented on the m_ ports in the cycle after the byte that causes it
// is accepted; the path is the parse logic between the frame state
// registers and the output register. s_ready stays high while the output
// register is empty or being read, so a stalled receiver holds input only
// once a result is waiting. Reset (aresetn low, synchronous) drops any
// pending result and returns the parser to the start of a frame.
// ----------------------------------------------------------------------------
module ax25_address_field_parser #(
    parameter int MAX_DIGIPEATERS = ax25p_pkg::MAX_DIGIPEATERS_DFLT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_frame_byte,
    input  logic                         s_frame_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [55:0]                  m_address_value,
    output logic [1:0]                   m_address_role,
    output logic [2:0]                   m_digi_index,
    output logic                         m_has_repeated,
    output logic                         m_field_done,
    output logic [1:0]                   m_status,
    output logic [1:0]                   m_cmd_resp,
    output logic                         m_dama_seen,
    output logic [2:0]                   m_digi_total,
    output logic signed [3:0]            m_last_repeat,
    output logic [5:0]                   m_header_length
);
    import ax25p_pkg::*;

    logic    s_beat;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign s_beat = s_valid && s_ready;

    ax25p_core #(
        .MAX_DIGIPEATERS (MAX_DIGIPEATERS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (s_beat),
        .frame_byte (s_frame_byte),
        .frame_end  (s_frame_end),
        .res_valid  (res_valid),
        .res        (res)
    );

    ax25p_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_beat && res_valid),
        .load_data (res),
        .accept_ok (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_address_value = out_data.address_value;
    assign m_address_role  = out_data.address_role;
    assign m_digi_index    = out_data.digi_index;
    assign m_has_repeated  = out_data.has_repeated;
    assign m_field_done    = out_data.field_done;
    assign m_status        = out_data.status;
    assign m_cmd_resp      = out_data.cmd_resp;
    assign m_dama_seen     = out_data.dama_seen;
    assign m_digi_total    = out_data.digi_total;
    assign m_last_repeat   = out_data.last_repeat;
    assign m_header_length = out_data.header_length;

endmodule
